>>> hdl/wilder_rsi_indicator_core_defines.svh
// assertion macros for the wilder rsi indicator core
// used by files that carry concurrent assertions; expects clk and arst_n in scope
`ifndef WILDER_RSI_INDICATOR_CORE_DEFINES_SVH
`define WILDER_RSI_INDICATOR_CORE_DEFINES_SVH

// same-cycle implication
`define WRSI_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wrsi assertion failed");

// next-cycle implication
`define WRSI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wrsi assertion failed");

`endif

>>> hdl/wrsi_pkg.sv
// package for the wilder rsi indicator core: widths, codes, reset values, structs
// no dependencies
package wrsi_pkg;

	localparam int PRICE_BITS    = 32;
	localparam int FRACTION_BITS = 16;
	localparam int PERIOD_BITS   = 8;
	localparam int THR_BITS      = 15;
	localparam int RSI_BITS      = 15;
	localparam int SIG_BITS      = 2;

	localparam int AVG_BITS = PRICE_BITS + PERIOD_BITS + FRACTION_BITS;
	localparam int DVD_BITS = AVG_BITS + PERIOD_BITS;
	localparam int DEN_BITS = AVG_BITS + 1;
	localparam int NUM_BITS = AVG_BITS + RSI_BITS;
	localparam int SH_BITS  = AVG_BITS;
	localparam int CNT_BITS = $clog2(SH_BITS + 1);

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 15;

	localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BUY    = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SELL   = 2'd2;

	localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 8'd14;
	localparam logic [THR_BITS-1:0]    BUY_RESET    = 15'd7680;
	localparam logic [THR_BITS-1:0]    SELL_RESET   = 15'd17920;

	localparam logic [RSI_BITS-1:0] RSI_FULL    = 15'd25600;
	localparam logic [RSI_BITS-1:0] RSI_NO_LOSS = RSI_BITS'((25600 * 100) / 101);

	localparam logic [SIG_BITS-1:0] SIG_HOLD = 2'd0;
	localparam logic [SIG_BITS-1:0] SIG_BUY  = 2'd1;
	localparam logic [SIG_BITS-1:0] SIG_SELL = 2'd2;

	localparam logic [CNT_BITS-1:0] AVG_STEPS = CNT_BITS'(SH_BITS);
	localparam logic [CNT_BITS-1:0] RSI_STEPS = CNT_BITS'(RSI_BITS);

	typedef struct packed {
		logic [PERIOD_BITS-1:0] period;
		logic [THR_BITS-1:0]    buy;
		logic [THR_BITS-1:0]    sell;
	} cfg_t;

	typedef struct packed {
		logic                start;
		logic [DEN_BITS-1:0] rem_init;
		logic [SH_BITS-1:0]  bits;
		logic [CNT_BITS-1:0] steps;
		logic [DEN_BITS-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [SH_BITS-1:0] quo;
	} div_rsp_t;

endpackage

>>> hdl/wrsi_sample_if.sv
// input channel of the wilder rsi indicator core: valid, ready, price, restart
// depends on wrsi_pkg
interface wrsi_sample_if;
	logic                           valid;
	logic                           ready;
	logic [wrsi_pkg::PRICE_BITS-1:0] price;
	logic                           restart;

	modport source (output valid, output price, output restart, input ready);
	modport sink (input valid, input price, input restart, output ready);
endinterface

>>> hdl/wrsi_result_if.sv
// output channel of the wilder rsi indicator core: valid, ready, rsi_value, trade_signal
// depends on wrsi_pkg
interface wrsi_result_if;
	logic                          valid;
	logic                          ready;
	logic [wrsi_pkg::RSI_BITS-1:0] rsi_value;
	logic [wrsi_pkg::SIG_BITS-1:0] trade_signal;

	modport source (output valid, output rsi_value, output trade_signal, input ready);
	modport sink (input valid, input rsi_value, input trade_signal, output ready);
endinterface

>>> hdl/wilder_rsi_indicator_core.sv
// flow: a series start or a warm-up price before the period is reached gives no result;
// any other price raises output valid after two average divides on the shared divider and,
// unless the average loss is zero, an rsi divide on the shared divider as well
// throughput: one transaction at a time, sample.ready is low while it is at work and while
// the result waits for a free output register; the next one can be taken in the cycle after that
// reset: arst_n clears the series state and output valid and loads the default config
module wilder_rsi_indicator_core (
	input  logic                               clk,
	input  logic                               arst_n,
	wrsi_sample_if.sink                        sample,
	wrsi_result_if.source                      result,
	input  logic                               wr_en,
	input  logic [wrsi_pkg::CFG_IDX_BITS-1:0]  wr_index,
	input  logic [wrsi_pkg::CFG_DATA_BITS-1:0] wr_data
);

	`include "wilder_rsi_indicator_core_defines.svh"

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_PREP   = 3'd1;
	localparam logic [2:0] S_START  = 3'd2;
	localparam logic [2:0] S_WAIT   = 3'd3;
	localparam logic [2:0] S_RPREP  = 3'd4;
	localparam logic [2:0] S_RSTART = 3'd5;
	localparam logic [2:0] S_RWAIT  = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	localparam int AVG  = wrsi_pkg::AVG_BITS;
	localparam int PB   = wrsi_pkg::PRICE_BITS;
	localparam int FB   = wrsi_pkg::FRACTION_BITS;
	localparam int PDB  = wrsi_pkg::PERIOD_BITS;
	localparam int RB   = wrsi_pkg::RSI_BITS;
	localparam int NB   = wrsi_pkg::NUM_BITS;
	localparam int DB   = wrsi_pkg::DEN_BITS;
	localparam int DVB  = wrsi_pkg::DVD_BITS;
	localparam int SHB  = wrsi_pkg::SH_BITS;

	wrsi_pkg::cfg_t     cfg;
	wrsi_pkg::div_req_t div_req;
	wrsi_pkg::div_rsp_t div_rsp;

	logic [2:0]      state_q;
	logic [PB-1:0]   last_price_q;
	logic            have_last_q;
	logic [7:0]      changes_q;
	logic            smooth_on_q;
	logic            warm_div_q;
	logic            sel_q;
	logic [AVG-1:0]  gain_avg_q;
	logic [AVG-1:0]  loss_avg_q;
	logic [PB-1:0]   gain_x_q;
	logic [PB-1:0]   loss_x_q;
	logic [DVB-1:0]  dvd_q;
	logic [NB-1:0]   num_q;
	logic [DB-1:0]   den_q;
	logic [RB-1:0]   rsi_res_q;
	logic            out_valid_q;
	logic [RB-1:0]   out_rsi_q;
	logic [1:0]      out_sig_q;

	logic            accept;
	logic [PB-1:0]   gain_w;
	logic [PB-1:0]   loss_w;
	logic [PDB-1:0]  period_w;
	logic [PDB-1:0]  pm1_w;
	logic [7:0]      changes_next;
	logic [AVG-1:0]  avg_sel;
	logic [PB-1:0]   x_sel;
	logic [DVB-1:0]  prod_w;
	logic [DVB-1:0]  dvd_w;
	logic [NB-1:0]   num_w;
	logic [1:0]      sig_w;
	logic            out_load;

	wrsi_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	wrsi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign sample.ready = (state_q == S_IDLE);
	assign accept       = sample.valid && sample.ready;

	always_comb begin
		gain_w       = (sample.price > last_price_q) ? sample.price - last_price_q : '0;
		loss_w       = (sample.price < last_price_q) ? last_price_q - sample.price : '0;
		period_w     = (cfg.period == '0) ? PDB'(1) : cfg.period;
		pm1_w        = period_w - 1'b1;
		changes_next = (changes_q == 8'hFF) ? changes_q : changes_q + 1'b1;
		avg_sel      = sel_q ? loss_avg_q : gain_avg_q;
		x_sel        = sel_q ? loss_x_q : gain_x_q;
		prod_w       = DVB'(avg_sel) * DVB'(pm1_w);
		dvd_w        = warm_div_q ? {avg_sel[DVB-FB-1:0], FB'(0)}
			: prod_w + DVB'({x_sel, FB'(0)});
		// 25600 = 2^14 + 2^13 + 2^10
		num_w        = (NB'(gain_avg_q) << 14) + (NB'(gain_avg_q) << 13)
			+ (NB'(gain_avg_q) << 10);
		if (rsi_res_q < cfg.buy) begin
			sig_w = wrsi_pkg::SIG_BUY;
		end else if (rsi_res_q > cfg.sell) begin
			sig_w = wrsi_pkg::SIG_SELL;
		end else begin
			sig_w = wrsi_pkg::SIG_HOLD;
		end
		out_load = (state_q == S_DONE) && (!out_valid_q || result.ready);
	end

	always_comb begin
		div_req.start    = 1'b0;
		div_req.rem_init = DB'(dvd_q[DVB-1:AVG]);
		div_req.bits     = dvd_q[AVG-1:0];
		div_req.steps    = wrsi_pkg::AVG_STEPS;
		div_req.den      = DB'(period_w);
		if (state_q == S_START) begin
			div_req.start = 1'b1;
		end else if (state_q == S_RSTART) begin
			div_req.start    = 1'b1;
			div_req.rem_init = DB'(num_q[NB-1:RB]);
			div_req.bits     = {num_q[RB-1:0], (SHB-RB)'(0)};
			div_req.steps    = wrsi_pkg::RSI_STEPS;
			div_req.den      = den_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			last_price_q <= '0;
			have_last_q  <= 1'b0;
			changes_q    <= '0;
			smooth_on_q  <= 1'b0;
			warm_div_q   <= 1'b0;
			sel_q        <= 1'b0;
			gain_avg_q   <= '0;
			loss_avg_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_price_q <= sample.price;
						have_last_q  <= 1'b1;
						sel_q        <= 1'b0;
						if (sample.restart || !have_last_q) begin
							changes_q   <= '0;
							gain_avg_q  <= '0;
							loss_avg_q  <= '0;
							smooth_on_q <= 1'b0;
						end else if (!smooth_on_q) begin
							gain_avg_q <= gain_avg_q + AVG'(gain_w);
							loss_avg_q <= loss_avg_q + AVG'(loss_w);
							changes_q  <= changes_next;
							if (changes_next >= period_w) begin
								smooth_on_q <= 1'b1;
								warm_div_q  <= 1'b1;
								state_q     <= S_PREP;
							end
						end else begin
							warm_div_q <= 1'b0;
							state_q    <= S_PREP;
						end
					end
				end
				S_PREP: begin
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_rsp.done) begin
						if (sel_q) begin
							loss_avg_q <= div_rsp.quo;
							state_q    <= S_RPREP;
						end else begin
							gain_avg_q <= div_rsp.quo;
							sel_q      <= 1'b1;
							state_q    <= S_PREP;
						end
					end
				end
				S_RPREP: begin
					state_q <= (loss_avg_q == '0) ? S_DONE : S_RSTART;
				end
				S_RSTART: begin
					state_q <= S_RWAIT;
				end
				S_RWAIT: begin
					if (div_rsp.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gain_x_q <= gain_w;
			loss_x_q <= loss_w;
		end
		if (state_q == S_PREP) begin
			dvd_q <= dvd_w;
		end
		if (state_q == S_RPREP) begin
			num_q     <= num_w;
			den_q     <= DB'(gain_avg_q) + DB'(loss_avg_q);
			rsi_res_q <= wrsi_pkg::RSI_NO_LOSS;
		end
		if (state_q == S_RWAIT && div_rsp.done) begin
			rsi_res_q <= div_rsp.quo[RB-1:0];
		end
		if (out_load) begin
			out_rsi_q <= rsi_res_q;
			out_sig_q <= sig_w;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.rsi_value    = out_rsi_q;
	assign result.trade_signal = out_sig_q;

	`WRSI_ASSERT_IMPLY(a_div_start_idle, div_req.start, !div_rsp.busy)
	`WRSI_ASSERT_IMPLY(a_div_done_wait, div_rsp.done, state_q == S_WAIT || state_q == S_RWAIT)
	`WRSI_ASSERT_NEXT(a_smooth_to_prep, accept && have_last_q && !sample.restart && smooth_on_q, state_q == S_PREP)
	`WRSI_ASSERT_IMPLY(a_rsi_range, result.valid, result.rsi_value <= wrsi_pkg::RSI_FULL)
	`WRSI_ASSERT_IMPLY(a_sig_code, result.valid, result.trade_signal != 2'd3)

endmodule

>>> hdl/wrsi_div.sv
// shared restoring divider, one quotient bit per cycle, preloadable partial remainder
// depends on wrsi_pkg
module wrsi_div (
	input  logic               clk,
	input  logic               arst_n,
	input  wrsi_pkg::div_req_t req,
	output wrsi_pkg::div_rsp_t rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [wrsi_pkg::CNT_BITS-1:0] cnt_q;
	logic [wrsi_pkg::DEN_BITS-1:0] rem_q;
	logic [wrsi_pkg::DEN_BITS-1:0] den_q;
	logic [wrsi_pkg::SH_BITS-1:0]  qd_q;

	logic [wrsi_pkg::DEN_BITS:0]   shifted;
	logic [wrsi_pkg::DEN_BITS:0]   trial;
	logic                          fits;

	always_comb begin
		shifted = {rem_q, qd_q[wrsi_pkg::SH_BITS-1]};
		trial   = shifted - {1'b0, den_q};
		fits    = (shifted >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == wrsi_pkg::CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			qd_q  <= req.bits;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= fits ? trial[wrsi_pkg::DEN_BITS-1:0] : shifted[wrsi_pkg::DEN_BITS-1:0];
			qd_q  <= {qd_q[wrsi_pkg::SH_BITS-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = qd_q;

endmodule

>>> hdl/wrsi_cfg.sv
// configuration registers: smoothing period and buy and sell thresholds
// depends on wrsi_pkg
module wrsi_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [wrsi_pkg::CFG_IDX_BITS-1:0]  wr_index,
	input  logic [wrsi_pkg::CFG_DATA_BITS-1:0] wr_data,
	output wrsi_pkg::cfg_t                     cfg
);

	wrsi_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period <= wrsi_pkg::PERIOD_RESET;
			cfg_q.buy    <= wrsi_pkg::BUY_RESET;
			cfg_q.sell   <= wrsi_pkg::SELL_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				wrsi_pkg::CFG_PERIOD: cfg_q.period <= wr_data[wrsi_pkg::PERIOD_BITS-1:0];
				wrsi_pkg::CFG_BUY:    cfg_q.buy    <= wr_data[wrsi_pkg::THR_BITS-1:0];
				wrsi_pkg::CFG_SELL:   cfg_q.sell   <= wr_data[wrsi_pkg::THR_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
